/* hdl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: the command that
// the front end hands to the back end, and the back end's states.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int POS_W  = 11;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;

	localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

	// Command queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef enum logic [1:0] {
		K_CHAR,
		K_CR,
		K_LF,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_SCROLL,
		ST_WIPE,
		ST_DONE
	} back_st_t;

endpackage

/* hdl/text_console_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console engine: cursor, character screen memory and scrolling.
// ----------------------------------------------------------------------------
// After reset the block zeroes the screen memory, one cell per cycle, and
// holds req_stall high until every cell is cleared. Each request then
// gives one response. A request is registered in the front end, passes
// through the command queue and is taken by the back end, which carries
// out one command at a time and takes no new one before it has given the
// last one's response; each command passes through a response state after
// its memory access. A put that scrolls the screen copies it up one row
// and blanks the bottom row, reading one cell and writing one cell per
// cycle, while the command queue keeps taking requests until it fills.
module text_console_writer_core import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              op,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [POS_W-1:0]  cursor_pos,
	output logic              scrolled,
	output logic [CHAR_W-1:0] cell_char
);

	logic clearing;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t pop_cmd;
	logic q_nempty;

	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.op         (op),
		.char_code  (char_code),
		.cell_index (cell_index),
		.clearing   (clearing),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full)
	);

	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.nempty   (q_nempty)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nempty   (q_nempty),
		.q_cmd      (pop_cmd),
		.pop        (pop),
		.clearing   (clearing),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cursor_pos (cursor_pos),
		.scrolled   (scrolled),
		.cell_char  (cell_char)
	);

endmodule

/* hdl/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Request front end: takes requests, classifies them into commands and
// pushes them into the command queue.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              op,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic              clearing,
	output logic              push,
	output cmd_t              push_cmd,
	input  logic              q_full
);

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t cmd_new;
	logic take;

	always_comb begin
		cmd_new.ch  = char_code;
		cmd_new.idx = cell_index;
		if (op) begin
			cmd_new.kind = K_READ;
		end else if (char_code == CH_CR) begin
			cmd_new.kind = K_CR;
		end else if (char_code == CH_LF) begin
			cmd_new.kind = K_LF;
		end else begin
			cmd_new.kind = K_CHAR;
		end
	end

	assign push      = vld_s1 && !q_full;
	assign push_cmd  = cmd_s1;
	assign req_stall = clearing || (vld_s1 && q_full);
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

/* hdl/tcw_queue.sv */
// ----------------------------------------------------------------------------
// tcw_queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic nempty
);

	cmd_t           slot_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign nempty  = (cnt_q != '0);
	assign pop_cmd = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

endmodule

/* hdl/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// Back end: owns the cursor and the screen memory, carries out commands,
// scrolls the screen and drives the registered response.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_nempty,
	input  cmd_t              q_cmd,
	output logic              pop,
	output logic              clearing,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [POS_W-1:0]  cursor_pos,
	output logic              scrolled,
	output logic [CHAR_W-1:0] cell_char
);

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int MOVE_END = CELLS - COLUMNS;
	localparam int AW       = $clog2(CELLS + 1);
	localparam int MW       = $clog2(CELLS);
	localparam int CW       = $clog2(COLUMNS);
	localparam int RW       = $clog2(ROWS + 1);

	localparam logic [AW-1:0] A_COLS = AW'(COLUMNS);
	localparam logic [AW-1:0] A_LAST = AW'(CELLS - 1);
	localparam logic [AW-1:0] A_MEND = AW'(MOVE_END);
	localparam logic [CW-1:0] C_LAST = CW'(COLUMNS - 1);
	localparam logic [RW-1:0] R_ROWS = RW'(ROWS);
	localparam logic [RW-1:0] R_LAST = RW'(ROWS - 1);

	logic [CHAR_W-1:0] mem [CELLS];
	logic [CHAR_W-1:0] rd_data_q;

	back_st_t st_q;
	back_st_t st_nx;

	logic [AW-1:0] pos_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] cnt_q;
	logic          mv_pend_q;
	logic [AW-1:0] mv_dst_q;
	logic          res_scr_q;
	logic [CHAR_W-1:0] res_cell_q;

	logic              rsp_vld_q;
	logic [POS_W-1:0]  cursor_pos_q;
	logic              scrolled_q;
	logic [CHAR_W-1:0] cell_char_q;

	logic [AW-1:0] pos_nx;
	logic [CW-1:0] col_nx;
	logic [RW-1:0] row_nx;
	logic          ovf;
	logic          is_read;
	logic          rd_hit;

	logic              wr_en;
	logic [MW-1:0]     wr_addr;
	logic [CHAR_W-1:0] wr_data;
	logic              rd_en;
	logic [MW-1:0]     rd_addr;
	logic              load_out;

	assign is_read = (q_cmd.kind == K_READ);
	assign rd_hit  = (32'(q_cmd.idx) < 32'(CELLS));

	// Cursor update for put commands.
	always_comb begin
		logic [AW-1:0] p;
		logic [CW-1:0] c;
		logic [RW-1:0] r;
		p = pos_q;
		c = col_q;
		r = row_q;
		case (q_cmd.kind)
			K_CR: begin
				p = pos_q - AW'(col_q);
				c = '0;
			end
			K_LF: begin
				p = pos_q + A_COLS - AW'(col_q);
				c = '0;
				r = row_q + 1'b1;
			end
			K_CHAR: begin
				p = pos_q + 1'b1;
				if (col_q == C_LAST) begin
					c = '0;
					r = row_q + 1'b1;
				end else begin
					c = col_q + 1'b1;
				end
			end
			default: begin
				p = pos_q;
			end
		endcase
		ovf = (r == R_ROWS);
		if (ovf) begin
			p = p - A_COLS;
			r = R_LAST;
		end
		pos_nx = p;
		col_nx = c;
		row_nx = r;
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_CLEAR: begin
				if (cnt_q == A_LAST) begin
					st_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_nempty) begin
					if (is_read) begin
						st_nx = rd_hit ? ST_RDWAIT : ST_DONE;
					end else begin
						st_nx = ovf ? ST_SCROLL : ST_DONE;
					end
				end
			end
			ST_RDWAIT: st_nx = ST_DONE;
			ST_SCROLL: begin
				if (cnt_q == A_MEND) begin
					st_nx = ST_WIPE;
				end
			end
			ST_WIPE: begin
				if (cnt_q == A_LAST) begin
					st_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					st_nx = ST_IDLE;
				end
			end
			default: st_nx = ST_CLEAR;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = MW'(cnt_q);
		wr_data  = '0;
		rd_en    = 1'b0;
		rd_addr  = MW'(q_cmd.idx);
		load_out = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				pop = q_nempty;
				if (q_nempty) begin
					if (is_read) begin
						rd_en = rd_hit;
					end else if (q_cmd.kind == K_CHAR) begin
						wr_en   = 1'b1;
						wr_addr = MW'(pos_q);
						wr_data = q_cmd.ch;
					end
				end
			end
			ST_SCROLL: begin
				wr_en   = mv_pend_q;
				wr_addr = MW'(mv_dst_q);
				wr_data = rd_data_q;
				if (cnt_q < A_MEND) begin
					rd_en   = 1'b1;
					rd_addr = MW'(cnt_q + A_COLS);
				end
			end
			ST_WIPE: begin
				wr_en = 1'b1;
			end
			ST_DONE: begin
				load_out = !rsp_vld_q || !rsp_stall;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			cnt_q     <= '0;
			pos_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			mv_pend_q <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			case (st_q)
				ST_CLEAR: cnt_q <= cnt_q + 1'b1;
				ST_IDLE: begin
					if (q_nempty && !is_read) begin
						pos_q <= pos_nx;
						col_q <= col_nx;
						row_q <= row_nx;
						cnt_q <= '0;
					end
				end
				ST_SCROLL: begin
					mv_pend_q <= (cnt_q < A_MEND);
					if (cnt_q < A_MEND) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WIPE: cnt_q <= cnt_q + 1'b1;
				default: begin
					mv_pend_q <= 1'b0;
				end
			endcase
			if (load_out) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_nempty) begin
			res_scr_q  <= !is_read && ovf;
			res_cell_q <= '0;
		end
		if (st_q == ST_RDWAIT) begin
			res_cell_q <= rd_data_q;
		end
		if (st_q == ST_SCROLL) begin
			mv_dst_q <= cnt_q;
		end
		if (load_out) begin
			cursor_pos_q <= POS_W'(pos_q);
			scrolled_q   <= res_scr_q;
			cell_char_q  <= res_cell_q;
		end
	end

	assign clearing   = (st_q == ST_CLEAR);
	assign rsp_valid  = rsp_vld_q;
	assign cursor_pos = cursor_pos_q;
	assign scrolled   = scrolled_q;
	assign cell_char  = cell_char_q;

endmodule
